FILE: hdl/bcd_pkg.sv
package bcd_pkg;

    localparam int COLOR_W   = 64;
    localparam int ALPHA_W   = 64;
    localparam int S_DATA_W  = COLOR_W + ALPHA_W;
    localparam int RGBA_W    = 32;
    localparam int M_DATA_W  = 40;
    localparam int CNT_W     = 4;
    localparam logic [CNT_W-1:0] LAST_PIXEL = 4'd15;
    localparam int ASUM_W    = 11;
    localparam int QDEPTH    = 2;

    localparam logic FMT_BC1 = 1'b0;
    localparam logic FMT_BC3 = 1'b1;

    // One decoded block waiting for the pixel stage.
    typedef struct packed {
        logic [3:0][31:0] cpal;   // RGBA palette, alpha valid for BC1
        logic [7:0][7:0]  apal;   // alpha palette, used for BC3
        logic [15:0][1:0] cidx;
        logic [15:0][2:0] aidx;
        logic             bc3;
    } bcd_entry_t;

    function automatic logic [7:0] exp5(input logic [4:0] v);
        logic [13:0] t;
        t = 14'(v) * 14'd527 + 14'd23;
        return t[13:6];
    endfunction

    function automatic logic [7:0] exp6(input logic [5:0] v);
        logic [13:0] t;
        t = 14'(v) * 14'd259 + 14'd33;
        return t[13:6];
    endfunction

    // Two thirds of the way from b toward a, 5-bit channel.
    function automatic logic [7:0] third5(input logic [4:0] a, input logic [4:0] b);
        logic [15:0] t;
        t = (16'(a) * 16'd2 + 16'(b)) * 16'd351 + 16'd61;
        return t[14:7];
    endfunction

    function automatic logic [7:0] third6(input logic [5:0] a, input logic [5:0] b);
        logic [18:0] t;
        t = (19'(a) * 19'd2 + 19'(b)) * 19'd2763 + 19'd1039;
        return t[18:11];
    endfunction

    function automatic logic [7:0] mid5(input logic [4:0] a, input logic [4:0] b);
        logic [15:0] t;
        t = (16'(a) + 16'(b)) * 16'd1053 + 16'd125;
        return t[15:8];
    endfunction

    function automatic logic [7:0] mid6(input logic [5:0] a, input logic [5:0] b);
        logic [18:0] t;
        t = (19'(a) + 19'(b)) * 19'd4145 + 19'd1019;
        return t[18:11];
    endfunction

    // Exact floor(s / 7) for s below 1792, by reciprocal multiply.
    function automatic logic [7:0] div7(input logic [ASUM_W-1:0] s);
        logic [24:0] p;
        p = 25'(s) * 25'd2341;
        return p[21:14];
    endfunction

    // Exact floor(s / 5) for s below 1280, by reciprocal multiply.
    function automatic logic [7:0] div5(input logic [ASUM_W-1:0] s);
        logic [24:0] p;
        p = 25'(s) * 25'd3277;
        return p[21:14];
    endfunction

endpackage

FILE: hdl/bcd_front.sv
module bcd_front (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [bcd_pkg::COLOR_W-1:0]  in_color,
    input  logic [bcd_pkg::ALPHA_W-1:0]  in_alpha,
    input  logic                         fmt,
    output logic                         out_valid,
    input  logic                         out_ready,
    output bcd_pkg::bcd_entry_t          out_entry
);

    logic adv;

    // Stage 1 registers: endpoints, interpolants, alpha weighted sums.
    logic                             st1_valid_reg;
    logic [23:0]                      ep0_reg, ep1_reg, thr2_reg, thr3_reg, mid_reg;
    logic                             four_reg, bc3_reg, six_reg;
    logic [7:0]                       a0_reg, a1_reg;
    logic [5:0][bcd_pkg::ASUM_W-1:0]  s6_reg;
    logic [3:0][bcd_pkg::ASUM_W-1:0]  s4_reg;
    logic [15:0][1:0]                 cidx_reg;
    logic [15:0][2:0]                 aidx_reg;

    logic [23:0]                      ep0_next, ep1_next, thr2_next, thr3_next, mid_next;
    logic [5:0][bcd_pkg::ASUM_W-1:0]  s6_next;
    logic [3:0][bcd_pkg::ASUM_W-1:0]  s4_next;

    // Stage 2 register: finished palettes.
    logic                st2_valid_reg;
    bcd_pkg::bcd_entry_t st2_reg, st2_next;

    logic [15:0] c0, c1;
    logic [4:0]  r0, r1, b0, b1;
    logic [5:0]  g0, g1;
    logic [7:0]  a0, a1;

    assign adv      = !st2_valid_reg || out_ready;
    assign in_ready = adv;

    always_comb begin
        c0 = in_color[15:0];
        c1 = in_color[31:16];
        r0 = c0[15:11];
        g0 = c0[10:5];
        b0 = c0[4:0];
        r1 = c1[15:11];
        g1 = c1[10:5];
        b1 = c1[4:0];
        a0 = in_alpha[7:0];
        a1 = in_alpha[15:8];
        ep0_next  = {bcd_pkg::exp5(b0), bcd_pkg::exp6(g0), bcd_pkg::exp5(r0)};
        ep1_next  = {bcd_pkg::exp5(b1), bcd_pkg::exp6(g1), bcd_pkg::exp5(r1)};
        thr2_next = {bcd_pkg::third5(b0, b1), bcd_pkg::third6(g0, g1),
                     bcd_pkg::third5(r0, r1)};
        thr3_next = {bcd_pkg::third5(b1, b0), bcd_pkg::third6(g1, g0),
                     bcd_pkg::third5(r1, r0)};
        mid_next  = {bcd_pkg::mid5(b0, b1), bcd_pkg::mid6(g0, g1), bcd_pkg::mid5(r0, r1)};
        for (int k = 1; k <= 6; k++) begin
            s6_next[k-1] = bcd_pkg::ASUM_W'(7 - k) * bcd_pkg::ASUM_W'(a0)
                         + bcd_pkg::ASUM_W'(k) * bcd_pkg::ASUM_W'(a1)
                         + bcd_pkg::ASUM_W'(1);
        end
        for (int k = 1; k <= 4; k++) begin
            s4_next[k-1] = bcd_pkg::ASUM_W'(5 - k) * bcd_pkg::ASUM_W'(a0)
                         + bcd_pkg::ASUM_W'(k) * bcd_pkg::ASUM_W'(a1)
                         + bcd_pkg::ASUM_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st1_valid_reg <= 1'b0;
        end else if (adv) begin
            st1_valid_reg <= in_valid;
        end
        if (adv) begin
            ep0_reg  <= ep0_next;
            ep1_reg  <= ep1_next;
            thr2_reg <= thr2_next;
            thr3_reg <= thr3_next;
            mid_reg  <= mid_next;
            bc3_reg  <= (fmt == bcd_pkg::FMT_BC3);
            four_reg <= (c0 > c1) || (fmt == bcd_pkg::FMT_BC3);
            six_reg  <= (a0 > a1);
            a0_reg   <= a0;
            a1_reg   <= a1;
            s6_reg   <= s6_next;
            s4_reg   <= s4_next;
            cidx_reg <= in_color[63:32];
            aidx_reg <= in_alpha[63:16];
        end
    end

    always_comb begin
        st2_next.cpal[0] = {8'hFF, ep0_reg};
        st2_next.cpal[1] = {8'hFF, ep1_reg};
        if (four_reg) begin
            st2_next.cpal[2] = {8'hFF, thr2_reg};
            st2_next.cpal[3] = {8'hFF, thr3_reg};
        end else begin
            // Three-color block: midpoint plus transparent black.
            st2_next.cpal[2] = {8'hFF, mid_reg};
            st2_next.cpal[3] = 32'h0;
        end
        st2_next.apal[0] = a0_reg;
        st2_next.apal[1] = a1_reg;
        if (six_reg) begin
            for (int k = 0; k < 6; k++) begin
                st2_next.apal[k+2] = bcd_pkg::div7(s6_reg[k]);
            end
        end else begin
            for (int k = 0; k < 4; k++) begin
                st2_next.apal[k+2] = bcd_pkg::div5(s4_reg[k]);
            end
            st2_next.apal[6] = 8'h00;
            st2_next.apal[7] = 8'hFF;
        end
        st2_next.cidx = cidx_reg;
        st2_next.aidx = aidx_reg;
        st2_next.bc3  = bc3_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st2_valid_reg <= 1'b0;
        end else if (adv) begin
            st2_valid_reg <= st1_valid_reg;
        end
        if (adv) begin
            st2_reg <= st2_next;
        end
    end

    assign out_valid = st2_valid_reg;
    assign out_entry = st2_reg;

endmodule

FILE: hdl/bcd_queue.sv
module bcd_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  bcd_pkg::bcd_entry_t in_entry,
    output logic                out_valid,
    input  logic                out_pop,
    output bcd_pkg::bcd_entry_t out_entry
);

    bcd_pkg::bcd_entry_t entry_reg [bcd_pkg::QDEPTH];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push, pop;

    assign in_ready  = (count_reg != 2'(bcd_pkg::QDEPTH));
    assign out_valid = (count_reg != 2'd0);
    assign push      = in_valid && in_ready;
    assign pop       = out_pop && out_valid;
    assign out_entry = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
        if (push) begin
            entry_reg[wr_ptr_reg] <= in_entry;
        end
    end

endmodule

FILE: hdl/bcd_back.sv
module bcd_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    output logic                          in_pop,
    input  bcd_pkg::bcd_entry_t           in_entry,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [bcd_pkg::RGBA_W-1:0]    m_rgba,
    output logic [1:0]                    m_x,
    output logic [1:0]                    m_y,
    output logic                          m_last
);

    logic [bcd_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic                      valid_reg, valid_next;
    logic [bcd_pkg::RGBA_W-1:0] rgba_reg, rgba_next;
    logic [1:0]                x_reg, y_reg;
    logic                      last_reg;
    logic                      load;

    assign load   = in_valid && (!valid_reg || m_ready);
    assign in_pop = load && (cnt_reg == bcd_pkg::LAST_PIXEL);

    always_comb begin
        rgba_next = in_entry.cpal[in_entry.cidx[cnt_reg]];
        if (in_entry.bc3) begin
            rgba_next[31:24] = in_entry.apal[in_entry.aidx[cnt_reg]];
        end
        cnt_next   = load ? cnt_reg + 4'd1 : cnt_reg;
        valid_next = load || (valid_reg && !m_ready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg   <= '0;
            valid_reg <= 1'b0;
        end else begin
            cnt_reg   <= cnt_next;
            valid_reg <= valid_next;
        end
        if (load) begin
            rgba_reg <= rgba_next;
            x_reg    <= cnt_reg[1:0];
            y_reg    <= cnt_reg[3:2];
            last_reg <= (cnt_reg == bcd_pkg::LAST_PIXEL);
        end
    end

    assign m_valid = valid_reg;
    assign m_rgba  = rgba_reg;
    assign m_x     = x_reg;
    assign m_y     = y_reg;
    assign m_last  = last_reg;

endmodule

FILE: hdl/bc1_bc3_texture_block_decoder.sv
// BC1 / BC3 block decoder. Each request on the slave stream carries one
// compressed 4x4 block (color half in the low 64 bits, alpha half above it),
// and the master stream returns its sixteen pixels in raster order as RGBA8
// words packed 0xAABBGGRR, with tlast on the sixteenth. The format register
// (0 = BC1, 1 = BC3) is sampled when a block is accepted and should only be
// written while the decoder is idle. The front end builds both palettes in
// two pipeline stages, a two-entry block queue follows, and the pixel stage
// emits one pixel per cycle while a block is queued and m_tready is high.
// Sustained throughput is therefore set by the pixel stage. The first pixel
// of a block passes the stage-1 and stage-2 registers, the queue entry and the
// pixel output register, and new blocks are taken while earlier pixels are
// still being sent.
module bc1_bc3_texture_block_decoder (
    input  logic                           aclk,
    input  logic                           aresetn,
    // Configuration: format bit.
    input  logic                           cfg_we,
    input  logic                           cfg_wdata,
    // Block input.
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [bcd_pkg::S_DATA_W-1:0]   s_tdata,  // color_word[63:0], alpha_word[127:64]
    // Pixel output.
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [bcd_pkg::M_DATA_W-1:0]   m_tdata,  // pixel_rgba[31:0], pixel_x[33:32],
                                                     // pixel_y[35:34], zero[39:36]
    output logic                           m_tlast
);

    logic                format_reg;
    logic                fr_valid, fr_ready;
    bcd_pkg::bcd_entry_t fr_entry;
    logic                q_valid, q_pop;
    bcd_pkg::bcd_entry_t q_entry;
    logic [bcd_pkg::RGBA_W-1:0] px_rgba;
    logic [1:0]          px_x, px_y;

    // The format register is the only configuration state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            format_reg <= bcd_pkg::FMT_BC1;
        end else if (cfg_we) begin
            format_reg <= cfg_wdata;
        end
    end

    // Front end: unpacks endpoints and builds the color and alpha palettes.
    bcd_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_color  (s_tdata[bcd_pkg::COLOR_W-1:0]),
        .in_alpha  (s_tdata[bcd_pkg::S_DATA_W-1:bcd_pkg::COLOR_W]),
        .fmt       (format_reg),
        .out_valid (fr_valid),
        .out_ready (fr_ready),
        .out_entry (fr_entry)
    );

    // Two decoded blocks may wait here so the front end keeps accepting
    // while the pixel stage drains the current block.
    bcd_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fr_valid),
        .in_ready  (fr_ready),
        .in_entry  (fr_entry),
        .out_valid (q_valid),
        .out_pop   (q_pop),
        .out_entry (q_entry)
    );

    // Pixel stage: walks the sixteen indices and looks up the palettes.
    bcd_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (q_valid),
        .in_pop   (q_pop),
        .in_entry (q_entry),
        .m_valid  (m_tvalid),
        .m_ready  (m_tready),
        .m_rgba   (px_rgba),
        .m_x      (px_x),
        .m_y      (px_y),
        .m_last   (m_tlast)
    );

    assign m_tdata = {4'b0000, px_y, px_x, px_rgba};

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 1ps

module testbench;

    // Half the clock period (in ns) and how long reset is held (in cycles).
    localparam int CLK_HALF     = 6;
    localparam int RESET_CYCLES = 11;
    // Cycles to let pass after the last pixel before touching the format
    // register or ending the run.
    localparam int SETTLE_CYCLES = 8;
    localparam int TAIL_CYCLES   = 32;
    // Cycles without any accepted request on either stream before the run
    // is declared hung.
    localparam int STALL_LIMIT = 1000;
    // Random blocks per idling phase (three phases, about 320 in total).
    localparam int BLOCKS_PER_PHASE = 107;

    // Sixteen decoded pixels of one block, pixel 0 in the low word.
    typedef logic [15:0][31:0] block_px_t;

    // One pixel as it should leave the decoder.
    typedef struct packed {
        logic [31:0] rgba;
        logic [1:0]  col;
        logic [1:0]  row;
        logic        last;
    } pixel_t;

    // One directed block. Where is_typed is set, all sixteen pixels must
    // equal typed_rgba; otherwise the pixels come from decode_block().
    typedef struct packed {
        logic        fmt;
        logic [63:0] color_word;
        logic [63:0] alpha_word;
        logic        is_typed;
        logic [31:0] typed_rgba;
    } dir_row_t;

    localparam int NDIR = 19;

    // Alpha index pattern 0xF4C688 gives the alpha indices 0, 1, 2, 3, 4, 1, 5, 7 in order;
    // color index byte 0xE4 walks the color indices 0..3.
    localparam dir_row_t DIR_TAB [NDIR] = '{
        // BC1: both endpoints zero are equal, so the three-color palette is
        // used; index 0 gives opaque black and the alpha half is ignored.
        '{bcd_pkg::FMT_BC1, 64'h00000000_00000000, 64'h01234567_89ABCDEF, 1'b1, 32'hFF000000},
        // BC1: equal endpoints and index 3 everywhere give transparent black.
        '{bcd_pkg::FMT_BC1, 64'hFFFFFFFF_00000000, 64'h00000000_00000000, 1'b1, 32'h00000000},
        // BC1: c0 = white, c1 = black, index 0 gives opaque white.
        '{bcd_pkg::FMT_BC1, 64'h00000000_0000FFFF, 64'h00000000_00000000, 1'b1, 32'hFFFFFFFF},
        // Same endpoints, index 1 gives opaque black.
        '{bcd_pkg::FMT_BC1, 64'h55555555_0000FFFF, 64'h00000000_00000000, 1'b1, 32'hFF000000},
        // Four-color palette, every index.
        '{bcd_pkg::FMT_BC1, 64'hE4E4E4E4_0000FFFF, 64'h00000000_00000000, 1'b0, 32'h0},
        // c0 < c1: three colors plus transparent black, every index.
        '{bcd_pkg::FMT_BC1, 64'hE4E4E4E4_F81F07E0, 64'h00000000_00000000, 1'b0, 32'h0},
        // Equal nonzero endpoints, mixed indices.
        '{bcd_pkg::FMT_BC1, 64'h1B1B1B1B_A5A5A5A5, 64'h00000000_00000000, 1'b0, 32'h0},
        // Equal white endpoints with an all-ones alpha half that must be ignored.
        '{bcd_pkg::FMT_BC1, 64'h00000000_FFFFFFFF, 64'hFFFFFFFF_FFFFFFFF, 1'b1, 32'hFFFFFFFF},
        // All ones: equal endpoints, index 3 everywhere, transparent black.
        '{bcd_pkg::FMT_BC1, 64'hFFFFFFFF_FFFFFFFF, 64'hFFFFFFFF_FFFFFFFF, 1'b1, 32'h00000000},
        // Endpoints differing only in the lowest bit, c0 < c1.
        '{bcd_pkg::FMT_BC1, 64'h9C9C9C9C_00010000, 64'h00000000_00000000, 1'b0, 32'h0},
        // BC3: all zero, forced four-color, alpha palette entry 0 is zero.
        '{bcd_pkg::FMT_BC3, 64'h00000000_00000000, 64'h00000000_00000000, 1'b1, 32'h00000000},
        // BC3: all ones, color index 3 of white endpoints and alpha 255.
        '{bcd_pkg::FMT_BC3, 64'hFFFFFFFF_FFFFFFFF, 64'hFFFFFFFF_FFFFFFFF, 1'b1, 32'hFFFFFFFF},
        // BC3: a0 = a1 = 0 and index 7 everywhere selects the fixed 255.
        '{bcd_pkg::FMT_BC3, 64'h00000000_00000000, 64'hFFFFFFFF_FFFF0000, 1'b1, 32'hFF000000},
        // BC3: a0 = a1 = 255 and index 6 everywhere selects the fixed 0.
        '{bcd_pkg::FMT_BC3, 64'h00000000_00000000, 64'hDB6DB6DB_6DB6FFFF, 1'b1, 32'h00000000},
        // BC3: a0 > a1, six-step alpha, c0 < c1 still decoded as four-color.
        '{bcd_pkg::FMT_BC3, 64'hE4E4E4E4_F81F07E0, 64'hF4C688F4_C68810F0, 1'b0, 32'h0},
        // BC3: a0 < a1, four-step alpha plus 0 and 255.
        '{bcd_pkg::FMT_BC3, 64'h1B1B1B1B_07E0F81F, 64'hF4C688F4_C688F010, 1'b0, 32'h0},
        // BC3: equal color endpoints and equal alpha endpoints.
        '{bcd_pkg::FMT_BC3, 64'hE4E4E4E4_5A5A5A5A, 64'hF4C688F4_C6887777, 1'b0, 32'h0},
        // BC3: extreme endpoints in both halves.
        '{bcd_pkg::FMT_BC3, 64'h4E4E4E4E_FFFF0000, 64'h05397705_397700FF, 1'b0, 32'h0},
        // Back to BC1 with extreme endpoints, c0 < c1.
        '{bcd_pkg::FMT_BC1, 64'hE4E4E4E4_FFFF0000, 64'hF4C688F4_C688F010, 1'b0, 32'h0}
    };

    logic                          aclk = 1'b0;
    logic                          aresetn;
    logic                          cfg_we;
    logic                          cfg_wdata;
    logic                          s_tvalid;
    logic                          s_tready;
    logic [bcd_pkg::S_DATA_W-1:0]  s_tdata;
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic [bcd_pkg::M_DATA_W-1:0]  m_tdata;
    logic                          m_tlast;

    // Pixels still owed by the decoder, oldest first.
    pixel_t pending_px [$];
    // Our copy of the format register.
    logic   cur_fmt;
    int     err_count = 0;
    int     quiet_cycles = 0;
    // Percent of cycles in which the sender inserts a gap and the receiver
    // holds off m_tready.
    int     s_gap_pct = 0;
    int     m_stall_pct = 0;

    bc1_bc3_texture_block_decoder dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    always #CLK_HALF aclk = ~aclk;

    // Opaque RGBA word from three channel values; each is cut to 8 bits.
    function automatic logic [31:0] opaque_rgb(input int unsigned r, input int unsigned g,
                                               input int unsigned b);
        return {8'hFF, 8'(b), 8'(g), 8'(r)};
    endfunction

    // Decodes one block into its sixteen pixels. The palettes are built
    // from the endpoints first and then looked up per pixel.
    function automatic block_px_t decode_block(input logic [63:0] cw, input logic [63:0] aw,
                                               input logic bc3);
        int unsigned      r0, g0, b0, r1, g1, b1;
        int unsigned      a0, a1, k;
        logic [3:0][31:0] cpal;
        logic [7:0][7:0]  apal;
        logic [1:0]       ci;
        logic [2:0]       ai;
        block_px_t        px;
        r0 = cw[15:11];
        g0 = cw[10:5];
        b0 = cw[4:0];
        r1 = cw[31:27];
        g1 = cw[26:21];
        b1 = cw[20:16];
        cpal[0] = opaque_rgb((r0 * 527 + 23) >> 6, (g0 * 259 + 33) >> 6, (b0 * 527 + 23) >> 6);
        cpal[1] = opaque_rgb((r1 * 527 + 23) >> 6, (g1 * 259 + 33) >> 6, (b1 * 527 + 23) >> 6);
        // BC3 always uses the four-color palette; BC1 only when c0 > c1.
        if (cw[15:0] > cw[31:16] || bc3) begin
            cpal[2] = opaque_rgb(((2 * r0 + r1) * 351 + 61) >> 7,
                                 ((2 * g0 + g1) * 2763 + 1039) >> 11,
                                 ((2 * b0 + b1) * 351 + 61) >> 7);
            cpal[3] = opaque_rgb(((r0 + 2 * r1) * 351 + 61) >> 7,
                                 ((g0 + 2 * g1) * 2763 + 1039) >> 11,
                                 ((b0 + 2 * b1) * 351 + 61) >> 7);
        end else begin
            cpal[2] = opaque_rgb(((r0 + r1) * 1053 + 125) >> 8,
                                 ((g0 + g1) * 4145 + 1019) >> 11,
                                 ((b0 + b1) * 1053 + 125) >> 8);
            cpal[3] = 32'h00000000;
        end
        a0 = aw[7:0];
        a1 = aw[15:8];
        apal[0] = 8'(a0);
        apal[1] = 8'(a1);
        if (a0 > a1) begin
            for (k = 1; k <= 6; k++) begin
                apal[k + 1] = 8'(((7 - k) * a0 + k * a1 + 1) / 7);
            end
        end else begin
            for (k = 1; k <= 4; k++) begin
                apal[k + 1] = 8'(((5 - k) * a0 + k * a1 + 1) / 5);
            end
            apal[6] = 8'h00;
            apal[7] = 8'hFF;
        end
        for (int i = 0; i < 16; i++) begin
            ci = cw[32 + 2 * i +: 2];
            px[i] = cpal[ci];
            if (bc3) begin
                ai = aw[16 + 3 * i +: 3];
                px[i][31:24] = apal[ai];
            end
        end
        return px;
    endfunction

    // Waits until the decoder has nothing left to send, lets the pipeline
    // settle, and then writes the format register. The sender stays quiet
    // for the whole pause.
    task automatic write_format(input logic fmt);
        s_tvalid <= 1'b0;
        while (pending_px.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= fmt;
        @(posedge aclk);
        cfg_we  <= 1'b0;
        cur_fmt = fmt;
    endtask

    // Offers one block on the slave stream, with random gaps in front of
    // it, and records the sixteen pixels it must produce once accepted.
    task automatic send_block(input logic [63:0] cw, input logic [63:0] aw,
                              input logic is_typed, input logic [31:0] typed_rgba);
        block_px_t px;
        while ($urandom_range(0, 99) < s_gap_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {aw, cw};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        // The format is sampled when the request is taken; it cannot change
        // while blocks are in flight, so cur_fmt is the right one here.
        px = is_typed ? {16{typed_rgba}} : decode_block(cw, aw, cur_fmt);
        for (int i = 0; i < 16; i++) begin
            pending_px.push_back(pixel_t'{px[i], 2'(i), 2'(i >> 2), i == 15});
        end
    endtask

    // Random block shaped so that every palette branch is hit often: equal,
    // ordered and reversed color endpoints, equal alpha endpoints, and extreme values in both halves.
    task automatic random_block(output logic [63:0] cw, output logic [63:0] aw);
        logic [15:0] lo;
        logic [15:0] hi;
        cw = {$urandom, $urandom};
        aw = {$urandom, $urandom};
        case ($urandom_range(0, 4))
            0: begin
                cw[31:16] = cw[15:0];
            end
            1: begin
                lo = (cw[15:0] < cw[31:16]) ? cw[15:0] : cw[31:16];
                hi = (cw[15:0] < cw[31:16]) ? cw[31:16] : cw[15:0];
                cw[31:0] = {lo, hi};
            end
            2: begin
                lo = (cw[15:0] < cw[31:16]) ? cw[15:0] : cw[31:16];
                hi = (cw[15:0] < cw[31:16]) ? cw[31:16] : cw[15:0];
                cw[31:0] = {hi, lo};
            end
            3: begin
                cw[15:0]  = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
                cw[31:16] = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            end
            default: begin
            end
        endcase
        case ($urandom_range(0, 3))
            0: aw[15:8] = aw[7:0];
            1: begin
                aw[7:0]  = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                aw[15:8] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            end
            default: begin
            end
        endcase
    endtask

    // Receiver: m_tready follows the current stall rate, one draw per cycle.
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= m_stall_pct);
    end

    // Compares one field of a pixel against its expectation.
    function automatic void check_field(input string what, input int idx,
                                        input logic [31:0] expv, input logic [31:0] actv);
        if (actv !== expv) begin
            $display("%0t: pixel %0d %s mismatch: expected %h, actual %h",
                     $time, idx, what, expv, actv);
            err_count++;
        end
    endfunction

    // Pixel checker. Each accepted pixel is matched against the oldest
    // expectation, field by field.
    always @(posedge aclk) begin
        pixel_t exp_px;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_px.size() == 0) begin
                $display("%0t: unexpected pixel: expected none, actual rgba %h x %0d y %0d",
                         $time, m_tdata[31:0], m_tdata[33:32], m_tdata[35:34]);
                err_count++;
            end else begin
                exp_px = pending_px.pop_front();
                check_field("rgba", {exp_px.row, exp_px.col}, exp_px.rgba, m_tdata[31:0]);
                check_field("x", {exp_px.row, exp_px.col}, exp_px.col, m_tdata[33:32]);
                check_field("y", {exp_px.row, exp_px.col}, exp_px.row, m_tdata[35:34]);
                check_field("last", {exp_px.row, exp_px.col}, exp_px.last, m_tlast);
            end
        end
    end

    // Watchdog: a request on either stream proves progress. A long quiet
    // stretch means the decoder has hung.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no request accepted for %0d cycles", $time, quiet_cycles);
            $display("FAIL bc1_bc3_texture_block_decoder");
            $finish;
        end
    end

    initial begin
        logic [63:0] cw;
        logic [63:0] aw;
        logic        fmt_sel;
        int          left;
        int          seg;
        aresetn   = 1'b0;
        cfg_we    = 1'b0;
        cfg_wdata = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        cur_fmt   = bcd_pkg::FMT_BC1;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part: light sender gaps, heavy receiver stalls. The
        // register is written before the first row and on every change of
        // format, each time after the decoder has drained.
        s_gap_pct   = 12;
        m_stall_pct = 84;
        for (int r = 0; r < NDIR; r++) begin
            if (r == 0 || DIR_TAB[r].fmt != cur_fmt) begin
                write_format(DIR_TAB[r].fmt);
            end
            send_block(DIR_TAB[r].color_word, DIR_TAB[r].alpha_word,
                       DIR_TAB[r].is_typed, DIR_TAB[r].typed_rgba);
        end

        // Random part in three idling phases. Each phase is cut into runs
        // of blocks; the format flips between runs so both modes see every
        // idling pattern, and the drain before each write also covers the
        // case of a sender that waits for all results.
        fmt_sel = 1'($urandom_range(0, 1));
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    s_gap_pct   = 12;
                    m_stall_pct = 84;
                end
                1: begin
                    s_gap_pct   = 84;
                    m_stall_pct = 12;
                end
                default: begin
                    s_gap_pct   = 0;
                    m_stall_pct = 0;
                end
            endcase
            left = BLOCKS_PER_PHASE;
            while (left > 0) begin
                seg = $urandom_range(10, 40);
                if (seg > left) begin
                    seg = left;
                end
                write_format(fmt_sel);
                fmt_sel = ~fmt_sel;
                for (int n = 0; n < seg; n++) begin
                    random_block(cw, aw);
                    send_block(cw, aw, 1'b0, 32'h0);
                end
                left -= seg;
            end
        end

        // Drain, then watch a little longer for stray pixels.
        s_tvalid <= 1'b0;
        while (pending_px.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (err_count == 0) begin
            $display("PASS bc1_bc3_texture_block_decoder");
        end else begin
            $display("FAIL bc1_bc3_texture_block_decoder");
        end
        $finish;
    end

endmodule
